// File: src/bdt_pkg.sv
// bdt_pkg: shared types and constants for the binary to decimal text block
// beat payload structs, controller/datapath command and status, char codes
// no dependencies
package bdt_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int RAW_W          = 64;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic [RAW_W-1:0] raw_value;
        logic             signed_mode;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last_char;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic skip_digit;
        logic emit_sign;
        logic emit_digit;
    } bdt_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic last_digit;
        logic neg;
        logic out_free;
    } bdt_status_t;

endpackage

// File: src/bdt_datapath.sv
// bdt_datapath: shift-and-add-3 binary to bcd converter, digit shifter, output register
// depends on bdt_pkg
module bdt_datapath
    import bdt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_data,
    input  bdt_cmd_t    cmd,
    output bdt_status_t status,
    input  logic        out_ready,
    output logic        out_valid,
    output out_item_t   out_data
);

    // decimal digits of 2^VALUE_BITS - 1
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int BCNT_W = $clog2(VALUE_BITS);
    localparam int DCNT_W = $clog2(DIGITS + 1);

    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next, bcd_adj;
    logic [BCNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DCNT_W-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                  neg_reg, neg_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg, out_data_next;

    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [3:0]            top_digit;

    assign in_val    = in_data.raw_value[VALUE_BITS-1:0];
    assign in_neg    = in_data.signed_mode & in_val[VALUE_BITS-1];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] inside {[4'd5:4'd15]})
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cmd.load)
        begin
            neg_next     = in_neg;
            shift_next   = in_neg ? (~in_val + 1'b1) : in_val;
            bcd_next     = '0;
            bit_cnt_next = '0;
            dig_cnt_next = DCNT_W'(DIGITS);
        end

        if (cmd.conv_step)
        begin
            bcd_next     = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_BITS-1]};
            shift_next   = {shift_reg[VALUE_BITS-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end

        if (cmd.skip_digit || cmd.emit_digit)
        begin
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            dig_cnt_next = dig_cnt_reg - 1'b1;
        end

        if (cmd.emit_sign)
        begin
            out_valid_next          = 1'b1;
            out_data_next.text_char = CHAR_MINUS;
            out_data_next.last_char = 1'b0;
        end

        if (cmd.emit_digit)
        begin
            out_valid_next          = 1'b1;
            out_data_next.text_char = CHAR_ZERO + {4'd0, top_digit};
            out_data_next.last_char = status.last_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    assign status.conv_done  = (bit_cnt_reg == BCNT_W'(VALUE_BITS - 1));
    assign status.top_zero   = (top_digit == 4'd0);
    assign status.last_digit = (dig_cnt_reg == DCNT_W'(1));
    assign status.neg        = neg_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a minus sign never ends the text
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.text_char == CHAR_MINUS) |-> !out_data_reg.last_char)
        else $error("minus sign marked as last character");

    // every beat is a minus or a decimal digit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.text_char == CHAR_MINUS) ||
            ((out_data_reg.text_char >= CHAR_ZERO) && (out_data_reg.text_char <= CHAR_NINE)))
        else $error("character outside the decimal set");

    // digits are only emitted while some remain
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit || cmd.skip_digit |-> dig_cnt_reg != '0)
        else $error("digit shifted past the end of the bcd register");

endmodule

// File: src/bdt_ctrl.sv
// bdt_ctrl: sequencer for load, bit-serial conversion, zero skip and char emission
// depends on bdt_pkg
module bdt_ctrl
    import bdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  bdt_status_t status,
    output bdt_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_done)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the last digit
                if (status.top_zero && !status.last_digit)
                    cmd.skip_digit = 1'b1;
                else
                    state_next = status.neg ? ST_SIGN : ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // the output register must have room when a char is written
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_sign || cmd.emit_digit |-> status.out_free)
        else $error("char written into an occupied output register");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.conv_step, cmd.skip_digit, cmd.emit_sign, cmd.emit_digit}))
        else $error("conflicting datapath commands");

    // after the final digit the next value can be taken at once
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_digit && status.last_digit |=> in_ready)
        else $error("input not ready after final character");

endmodule

// File: src/binary_to_decimal_text.sv
// Converts one VALUE_BITS-wide value per input beat (two's complement when signed_mode is set,
// unsigned otherwise; raw_value bits above VALUE_BITS are ignored) into its decimal ASCII text,
// one character per output beat, most significant first: a '-' for negative values, then the
// digits without leading zeros ('0' alone for zero); last_char marks the final character.
// The conversion is bit-serial shift-and-add-3, one input bit per cycle; an item occupies
// the block through its load, the conversion, the skip of leading zero digits, the step that
// leaves the zero skip and the delivery of each character (longer if out_ready stalls); no
// new value is taken before the final character is written to the output register, but the
// next value is accepted while that final character still waits in the output register.
module binary_to_decimal_text
    import bdt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    bdt_cmd_t    cmd;
    bdt_status_t status;

    bdt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bdt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: tb/bdt_text_checker.sv
`timescale 1ns / 100ps
// bdt_text_checker: watches both channels of binary_to_decimal_text, predicts the text
// of each accepted value and compares every output beat; depends on bdt_pkg
module bdt_text_checker
    import bdt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        mismatches,
    output int        chars_due
);

    out_item_t text_queue[$];
    int        fail_tally = 0;
    int        due_tally  = 0;

    assign mismatches = fail_tally;
    assign chars_due  = due_tally;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_tally++;
    endtask

    // decimal text of one value, most significant character first
    task automatic queue_decimal_text(input in_item_t item);
        logic [RAW_W-1:0] mask;
        logic [RAW_W-1:0] val;
        logic [RAW_W-1:0] mag;
        logic [RAW_W-1:0] rem;
        logic             neg;
        logic [3:0]       digits [0:19];
        int               nd;
        out_item_t        ch;
        mask = (VALUE_BITS >= RAW_W) ? {RAW_W{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
        val  = item.raw_value & mask;
        neg  = item.signed_mode && val[VALUE_BITS-1];
        mag  = neg ? ((~val + 64'd1) & mask) : val;
        nd   = 0;
        do
        begin
            rem = mag % 64'd10;
            digits[nd] = rem[3:0];
            nd++;
            mag = mag / 64'd10;
        end
        while (mag != 0 && nd < 20);
        if (neg)
        begin
            ch.text_char = CHAR_MINUS;
            ch.last_char = 1'b0;
            text_queue.push_back(ch);
        end
        for (int k = nd - 1; k >= 0; k--)
        begin
            ch.text_char = CHAR_ZERO + {4'd0, digits[k]};
            ch.last_char = (k == 0);
            text_queue.push_back(ch);
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (text_queue.size() == 0)
                    report_mismatch($sformatf("char 0x%02h last=%0b with nothing expected",
                                              out_data.text_char, out_data.last_char));
                else
                begin
                    want = text_queue.pop_front();
                    if (out_data.text_char !== want.text_char)
                        report_mismatch($sformatf("text_char 0x%02h, expected 0x%02h",
                                                  out_data.text_char, want.text_char));
                    if (out_data.last_char !== want.last_char)
                        report_mismatch($sformatf("last_char %0b, expected %0b on char 0x%02h",
                                                  out_data.last_char, want.last_char,
                                                  want.text_char));
                end
            end
            if (in_valid && in_ready)
                queue_decimal_text(in_data);
            due_tally <= text_queue.size();
        end
    end

endmodule

// File: tb/tb_binary_to_decimal_text.sv
`timescale 1ns / 100ps
// tb_binary_to_decimal_text: drives values into binary_to_decimal_text with random
// idling on both sides and gives the verdict; depends on bdt_pkg and bdt_text_checker
module tb_binary_to_decimal_text;
    import bdt_pkg::*;

    localparam int RANDOM_VALUES = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 120;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    int        mismatches;
    int        chars_due;
    logic      steady    = 1'b0;
    int        quiet_cycles = 0;

    always #2 clk = ~clk;

    binary_to_decimal_text dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    bdt_text_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .chars_due  (chars_due)
    );

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 30);

    // watchdog: cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_value(input logic [RAW_W-1:0] raw, input logic sm);
        int       gap;
        in_item_t item;
        gap = 0;
        if (!steady)
            while (gap < 8 && $urandom_range(99) < 30)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.raw_value   = raw;
        item.signed_mode = sm;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_text;
        while (chars_due != 0)
            @(posedge clk);
    endtask

    function automatic logic [RAW_W-1:0] random_value();
        logic [RAW_W-1:0] v;
        int               len;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: ;
            1:
            begin
                len = $urandom_range(64);
                if (len < 64)
                    v = v & ((64'd1 << len) - 64'd1);
            end
            2:
            begin
                // digit times a power of ten, so runs of inner zeros show up
                v = 64'd1;
                repeat ($urandom_range(19)) v = v * 64'd10;
                v = v * $urandom_range(1, 9) + (($urandom_range(1) != 0) ? $urandom_range(99) : 0);
            end
            default:
            begin
                case ($urandom_range(3))
                    0: v = 64'd0;
                    1: v = {RAW_W{1'b1}};
                    2: v = 64'h8000_0000_0000_0000;
                    default: v = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
                v = v ^ 64'($urandom_range(15));
            end
        endcase
        return v;
    endfunction

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_value(64'd0, 1'b0);
        send_value(64'd0, 1'b1);
        send_value(64'd1, 1'b0);
        send_value(64'd9, 1'b1);
        send_value(64'd10, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(64'h8000_0000_0000_0000, 1'b1);
        send_value(64'h8000_0000_0000_0000, 1'b0);
        send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
        send_value(64'hFFFF_FFFF_FFFF_FFF6, 1'b1);
        send_value(64'd100000000000, 1'b0);
        send_value(64'd4294967296, 1'b0);
        send_value(64'd4294967297000000001, 1'b0);
        send_value(64'd1000000000000000000, 1'b1);
        send_value(64'd10000000000000000000, 1'b0);
        send_value(64'd1000000001, 1'b0);
        send_value(64'h5555_5555_5555_5555, 1'b1);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_value(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);

        // sender holds off until all text is out
        in_valid <= 1'b0;
        @(posedge clk);
        drain_text();

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            if (i == 40)
                steady <= 1'b1;
            if (i == 70)
                steady <= 1'b0;
            if (i == 85)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                drain_text();
            end
            send_value(random_value(), 1'($urandom_range(1)));
        end
        in_valid <= 1'b0;
        @(posedge clk);

        drain_text();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_due == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: filelist.f
src/bdt_pkg.sv
src/bdt_datapath.sv
src/bdt_ctrl.sv
src/binary_to_decimal_text.sv
tb/bdt_text_checker.sv
tb/tb_binary_to_decimal_text.sv
